/* design/bsm_pkg.sv */
// ============================================================================
// bsm_pkg - shared types and constants for the sphere merge pipeline
// Holds the per-cell payload records handed down the row of cells.
// ============================================================================
`default_nettype none
package bsm_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned RadW    = 31;
  localparam int unsigned D2W     = 66;   // sum of three 64-bit squares
  localparam int unsigned SqrtW   = 33;   // floor sqrt of a value below 2^66
  localparam int unsigned DivW    = 36;   // quotient bits of the centre step
  localparam int unsigned ProdW   = 66;   // |offset| (33) times k (33)
  localparam int unsigned RW      = 34;   // merged radius before saturation

  localparam logic [RW-1:0] RadMax = RW'(34'h0_FFFF_FFFF);

  // Operands travelling with the square root row
  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic [RadW-1:0]          ra;
    logic [RadW-1:0]          rb;
    logic [2:0]               neg;      // offset sign per axis
    logic [CoordW:0]          mx;       // offset magnitudes
    logic [CoordW:0]          my;
    logic [CoordW:0]          mz;
    logic                     enclosed;
    logic [D2W-1:0]           d2;
  } sqrt_pay_t;

  // Operands travelling with the division row
  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic [RadW-1:0]          ra;
    logic [RadW-1:0]          rb;
    logic [2:0]               neg;
    logic                     enclosed;
    logic [SqrtW-1:0]         d;
    logic [RW-1:0]            r;
  } div_pay_t;

endpackage : bsm_pkg
`default_nettype wire

/* design/bsm_sqrt_cell.sv */
// ============================================================================
// bsm_sqrt_cell - one bit of the restoring square root
// Tries one root bit against the remainder and hands the result on.
// ============================================================================
`default_nettype none
module bsm_sqrt_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic [5:0]                   bit_idx,
  input  wire logic                         vld_i,
  input  wire logic [bsm_pkg::SqrtW-1:0]    q_i,
  input  wire logic [bsm_pkg::D2W:0]        rem_i,
  input  wire bsm_pkg::sqrt_pay_t           pay_i,
  output logic                              vld_o,
  output logic [bsm_pkg::SqrtW-1:0]         q_o,
  output logic [bsm_pkg::D2W:0]             rem_o,
  output bsm_pkg::sqrt_pay_t                pay_o
);

  logic [bsm_pkg::D2W:0]      trial;
  logic [bsm_pkg::SqrtW-1:0]  q_nxt;
  logic [bsm_pkg::D2W:0]      rem_nxt;

  // Subtract (2q + 2^i) * 2^i, i.e. (q << (i+1)) + (1 << 2i)
  always_comb begin
    trial   = ((bsm_pkg::D2W+1)'(q_i) << (bit_idx + 6'd1))
            + ((bsm_pkg::D2W+1)'(1) << {bit_idx, 1'b0});
    q_nxt   = q_i;
    rem_nxt = rem_i;
    if (trial <= rem_i) begin
      q_nxt   = q_i | (bsm_pkg::SqrtW'(1) << bit_idx);
      rem_nxt = rem_i - trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o   <= q_nxt;
      rem_o <= rem_nxt;
      pay_o <= pay_i;
    end
  end

endmodule : bsm_sqrt_cell
`default_nettype wire

/* design/bsm_div_cell.sv */
// ============================================================================
// bsm_div_cell - one quotient bit on all three axes
// Restoring division step of |offset|*k by d for x, y and z in parallel.
// ============================================================================
`default_nettype none
module bsm_div_cell (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic [5:0]                   bit_idx,
  input  wire logic                         vld_i,
  input  wire logic [3*bsm_pkg::DivW-1:0]   q_i,
  input  wire logic [3*bsm_pkg::ProdW-1:0]  rem_i,
  input  wire bsm_pkg::div_pay_t            pay_i,
  output logic                              vld_o,
  output logic [3*bsm_pkg::DivW-1:0]        q_o,
  output logic [3*bsm_pkg::ProdW-1:0]       rem_o,
  output bsm_pkg::div_pay_t                 pay_o
);

  logic [3*bsm_pkg::DivW-1:0]  q_nxt;
  logic [3*bsm_pkg::ProdW-1:0] rem_nxt;
  logic [bsm_pkg::ProdW+bsm_pkg::DivW-1:0] sub;

  // Accept quotient bit i where d << i still fits under the remainder
  always_comb begin
    q_nxt   = q_i;
    rem_nxt = rem_i;
    sub     = (bsm_pkg::ProdW+bsm_pkg::DivW)'(pay_i.d) << bit_idx;
    for (int a = 0; a < 3; a++) begin
      if (sub <= (bsm_pkg::ProdW+bsm_pkg::DivW)'(rem_i[a*bsm_pkg::ProdW +: bsm_pkg::ProdW]))
      begin
        q_nxt[a*bsm_pkg::DivW + bit_idx] = 1'b1;
        rem_nxt[a*bsm_pkg::ProdW +: bsm_pkg::ProdW] =
          rem_i[a*bsm_pkg::ProdW +: bsm_pkg::ProdW] - bsm_pkg::ProdW'(sub);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_o   <= q_nxt;
      rem_o <= rem_nxt;
      pay_o <= pay_i;
    end
  end

endmodule : bsm_div_cell
`default_nettype wire

/* design/bounding_sphere_merge.sv */
// Stages: 3 front, 33 root cells, 2 radius/product, 36 divide cells,
//   2 centre/growth stages, 1 output.
// Throughput: one pair per cycle; each root and divide cell takes a new pair
//   every cycle, and the whole row holds while the output register is stalled.
// Reset: synchronous active-low rst_n clears every valid flag; data unreset.
// ============================================================================
// bounding_sphere_merge - smallest sphere enclosing two spheres
// Squared distance, bit-per-cell square root, then a bit-per-cell divider
// for the centre step and a squaring stage for the growth term.
// ============================================================================
`default_nettype none
module bounding_sphere_merge (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // ax[31:0] ay[63:32] az[95:64] a_radius[126:96]
  // bx[158:127] by[190:159] bz[222:191] b_radius[253:223], zero [255:254]
  input  wire logic [255:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // merged_x[31:0] merged_y[63:32] merged_z[95:64] merged_radius[127:96]
  // growth[191:128]
  output logic [191:0]      out_tdata
);

  localparam int unsigned NS = bsm_pkg::SqrtW;
  localparam int unsigned ND = bsm_pkg::DivW;
  localparam int unsigned PW = bsm_pkg::ProdW;

  logic en;
  logic out_vld_r;
  logic [191:0] out_data_r;

  // Pipeline advances unless the output holds a result not yet taken
  assign en         = !out_vld_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // ---------------- stage F1: offsets ----------------
  logic f1_vld_r;
  logic signed [31:0] f1_a_r [3];
  logic signed [31:0] f1_b_r [3];
  logic [30:0] f1_ra_r, f1_rb_r;
  logic [2:0]  f1_neg_r;
  logic [32:0] f1_mag_r [3];
  logic [30:0] f1_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f1_vld_r <= 1'b0;
    else if (en) f1_vld_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        logic signed [32:0] off;
        off = 33'(signed'(in_tdata[127 + a*32 +: 32])) - 33'(signed'(in_tdata[a*32 +: 32]));
        f1_a_r[a]   <= in_tdata[a*32 +: 32];
        f1_b_r[a]   <= in_tdata[127 + a*32 +: 32];
        f1_neg_r[a] <= off[32];
        f1_mag_r[a] <= off[32] ? 33'(-off) : 33'(off);
      end
      f1_ra_r <= in_tdata[126:96];
      f1_rb_r <= in_tdata[253:223];
      f1_rd_r <= (in_tdata[126:96] > in_tdata[253:223]) ?
                 in_tdata[126:96] - in_tdata[253:223] : in_tdata[253:223] - in_tdata[126:96];
    end
  end

  // ---------------- stage F2: squares ----------------
  logic f2_vld_r;
  logic [65:0] f2_sq_r [3];
  logic [61:0] f2_rd2_r;
  bsm_pkg::sqrt_pay_t f2_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) f2_vld_r <= 1'b0;
    else if (en) f2_vld_r <= f1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) f2_sq_r[a] <= 66'(f1_mag_r[a]) * 66'(f1_mag_r[a]);
      f2_rd2_r <= 62'(f1_rd_r) * 62'(f1_rd_r);
      f2_pay_r.ax <= f1_a_r[0]; f2_pay_r.ay <= f1_a_r[1]; f2_pay_r.az <= f1_a_r[2];
      f2_pay_r.bx <= f1_b_r[0]; f2_pay_r.by <= f1_b_r[1]; f2_pay_r.bz <= f1_b_r[2];
      f2_pay_r.ra <= f1_ra_r; f2_pay_r.rb <= f1_rb_r;
      f2_pay_r.neg <= f1_neg_r;
      f2_pay_r.mx <= f1_mag_r[0]; f2_pay_r.my <= f1_mag_r[1]; f2_pay_r.mz <= f1_mag_r[2];
      f2_pay_r.enclosed <= 1'b0;
      f2_pay_r.d2 <= '0;
    end
  end

  // ---------------- stage F3: sum and containment test ----------------
  logic f3_vld_r;
  bsm_pkg::sqrt_pay_t f3_pay_r;
  bsm_pkg::sqrt_pay_t f3_pay;
  logic [65:0] f3_d2;

  assign f3_d2 = f2_sq_r[0] + f2_sq_r[1] + f2_sq_r[2];

  // Fold the squared distance and the containment test into the payload
  always_comb begin
    f3_pay          = f2_pay_r;
    f3_pay.d2       = f3_d2;
    f3_pay.enclosed = f3_d2 <= 66'(f2_rd2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f3_vld_r <= 1'b0;
    else if (en) f3_vld_r <= f2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f3_pay_r <= f3_pay;
    end
  end

  // ---------------- square root row ----------------
  logic               s_vld [NS+1];
  logic [NS-1:0]      s_q   [NS+1];
  logic [bsm_pkg::D2W:0] s_rem [NS+1];
  bsm_pkg::sqrt_pay_t s_pay [NS+1];

  assign s_vld[0] = f3_vld_r;
  assign s_q[0]   = '0;
  assign s_rem[0] = (bsm_pkg::D2W+1)'(f3_pay_r.d2);
  assign s_pay[0] = f3_pay_r;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    bsm_sqrt_cell u_cell (
      .clk, .rst_n, .en,
      .bit_idx (6'(NS-1-g)),
      .vld_i (s_vld[g]), .q_i (s_q[g]), .rem_i (s_rem[g]), .pay_i (s_pay[g]),
      .vld_o (s_vld[g+1]), .q_o (s_q[g+1]), .rem_o (s_rem[g+1]), .pay_o (s_pay[g+1])
    );
  end

  // ---------------- stage R1: merged radius ----------------
  logic r1_vld_r;
  bsm_pkg::div_pay_t r1_pay_r;
  logic [32:0] r1_m_r [3];
  logic [bsm_pkg::SqrtW-1:0] dq;
  logic [31:0] rsum;

  assign dq   = s_q[NS];
  assign rsum = 32'(s_pay[NS].ra) + 32'(s_pay[NS].rb);

  always_ff @(posedge clk) begin
    if (!rst_n) r1_vld_r <= 1'b0;
    else if (en) r1_vld_r <= s_vld[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_pay_r.ax <= s_pay[NS].ax; r1_pay_r.ay <= s_pay[NS].ay; r1_pay_r.az <= s_pay[NS].az;
      r1_pay_r.bx <= s_pay[NS].bx; r1_pay_r.by <= s_pay[NS].by; r1_pay_r.bz <= s_pay[NS].bz;
      r1_pay_r.ra <= s_pay[NS].ra; r1_pay_r.rb <= s_pay[NS].rb;
      r1_pay_r.neg <= s_pay[NS].neg;
      r1_pay_r.enclosed <= s_pay[NS].enclosed;
      r1_pay_r.d <= dq;
      r1_pay_r.r <= (34'(dq) + 34'(rsum)) >> 1;
      r1_m_r[0] <= s_pay[NS].mx; r1_m_r[1] <= s_pay[NS].my; r1_m_r[2] <= s_pay[NS].mz;
    end
  end

  // ---------------- stage R2: products |offset| * k ----------------
  logic r2_vld_r;
  bsm_pkg::div_pay_t r2_pay_r;
  logic [3*PW-1:0] r2_prod_r;
  logic [32:0] kk;

  assign kk = 33'(r1_pay_r.r - 34'(r1_pay_r.ra));

  always_ff @(posedge clk) begin
    if (!rst_n) r2_vld_r <= 1'b0;
    else if (en) r2_vld_r <= r1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_pay_r <= r1_pay_r;
      for (int a = 0; a < 3; a++)
        r2_prod_r[a*PW +: PW] <= PW'(r1_m_r[a]) * PW'(kk);
    end
  end

  // ---------------- division row ----------------
  logic              v_vld [ND+1];
  logic [3*ND-1:0]   v_q   [ND+1];
  logic [3*PW-1:0]   v_rem [ND+1];
  bsm_pkg::div_pay_t v_pay [ND+1];

  assign v_vld[0] = r2_vld_r;
  assign v_q[0]   = '0;
  assign v_rem[0] = r2_prod_r;
  assign v_pay[0] = r2_pay_r;

  for (genvar g = 0; g < ND; g++) begin : g_div
    bsm_div_cell u_cell (
      .clk, .rst_n, .en,
      .bit_idx (6'(ND-1-g)),
      .vld_i (v_vld[g]), .q_i (v_q[g]), .rem_i (v_rem[g]), .pay_i (v_pay[g]),
      .vld_o (v_vld[g+1]), .q_o (v_q[g+1]), .rem_o (v_rem[g+1]), .pay_o (v_pay[g+1])
    );
  end

  // ---------------- stage E1: centre, chosen radius ----------------
  bsm_pkg::div_pay_t dp;
  assign dp = v_pay[ND];

  logic e1_vld_r;
  logic [31:0] e1_c_r [3];
  logic [bsm_pkg::RW-1:0] e1_r_r;
  logic [30:0] e1_ra_r;
  logic e1_enc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e1_vld_r <= 1'b0;
    else if (en) e1_vld_r <= v_vld[ND];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [31:0] av [3];
      logic signed [31:0] bv [3];
      logic pick_a;
      av[0] = dp.ax; av[1] = dp.ay; av[2] = dp.az;
      bv[0] = dp.bx; bv[1] = dp.by; bv[2] = dp.bz;
      pick_a = dp.ra > dp.rb;
      for (int a = 0; a < 3; a++) begin
        logic signed [37:0] c;
        logic [ND-1:0] st;
        st = (dp.d != '0) ? v_q[ND][a*ND +: ND] : '0;
        c  = dp.neg[a] ? 38'(av[a]) - 38'(st) : 38'(av[a]) + 38'(st);
        if (dp.enclosed) e1_c_r[a] <= pick_a ? av[a] : bv[a];
        else if (c > 38'sd2147483647) e1_c_r[a] <= 32'h7FFF_FFFF;
        else if (c < -38'sd2147483648) e1_c_r[a] <= 32'h8000_0000;
        else e1_c_r[a] <= 32'(c);
      end
      e1_r_r   <= dp.enclosed ? 34'(pick_a ? dp.ra : dp.rb) : dp.r;
      e1_ra_r  <= dp.ra;
      e1_enc_r <= dp.enclosed;
    end
  end

  // ---------------- stage E2: squares for growth ----------------
  logic e2_vld_r;
  logic [31:0] e2_c_r [3];
  logic [31:0] e2_rs_r;
  logic [67:0] e2_r2_r;
  logic [61:0] e2_ra2_r;
  logic e2_enc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e2_vld_r <= 1'b0;
    else if (en) e2_vld_r <= e1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_c_r   <= e1_c_r;
      e2_rs_r  <= (e1_r_r > bsm_pkg::RadMax) ? 32'hFFFF_FFFF : 32'(e1_r_r);
      e2_r2_r  <= 68'(e1_r_r) * 68'(e1_r_r);
      e2_ra2_r <= 62'(e1_ra_r) * 62'(e1_ra_r);
      e2_enc_r <= e1_enc_r;
    end
  end

  // ---------------- stage E3: growth and output register ----------------
  logic signed [68:0] gdiff;
  logic [63:0] growth;

  assign gdiff = signed'({1'b0, e2_r2_r}) - signed'(69'(e2_ra2_r));
  assign growth = e2_enc_r ? 64'(gdiff)
                : (gdiff > 69'sh0_7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF
                : 64'(gdiff);

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= e2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= {growth, e2_rs_r, e2_c_r[2], e2_c_r[1], e2_c_r[0]};
  end

endmodule : bounding_sphere_merge
`default_nettype wire
